// ===== hw/rtl/ssmg_pkg.sv =====
// ----------------------------------------------------------------------------
// ssmg_pkg
// Shared constants, operation codes and the command and status bundles that
// join the controller and the datapath of the sorted set minimum gap tracker.
// ----------------------------------------------------------------------------
package ssmg_pkg;

  // Default sizing of the block.
  localparam int unsigned CAPACITY_DEF   = 64;
  localparam int unsigned VALUE_BITS_DEF = 32;

  // Fixed widths of the channel fields.
  localparam int unsigned FUNC_W  = 1;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned GAP_W   = 32;
  localparam int unsigned POS_W   = 6;
  localparam int unsigned COUNT_W = 7;

  // Operation codes carried in the func field.
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 1'b1;

  // One step of work that the controller asks of the datapath.
  typedef struct packed {
    logic load;       // capture a new input beat
    logic rd;         // read the store at the walk index
    logic ins_ev;     // insert: compare read entry, shift it up or place value
    logic ins_place;  // insert: place value at slot zero
    logic ins_gapl;   // insert: bump count, check the left gap
    logic ins_gapr;   // insert: check the right gap
    logic rem_ev;     // remove: match, shift down and rescan survivors
    logic rem_fin;    // remove: commit count and minimum gap
    logic emit;       // load the result register
  } cmd_t;

  // Conditions that steer the controller.
  typedef struct packed {
    logic full;       // table holds CAPACITY entries
    logic empty;      // table holds nothing
    logic ge;         // read entry is not smaller than the operand
    logic idx_zero;   // walk index is at slot zero
    logic idx_last;   // walk index is at the last held entry
    logic out_busy;   // result register holds a beat that is not taken
  } status_t;

endpackage

// ===== hw/rtl/ssmg_chan_if.sv =====
// ----------------------------------------------------------------------------
// ssmg channel interfaces
// Valid/ready channels for operation beats into the tracker and result beats
// out of it.
// ----------------------------------------------------------------------------
interface ssmg_in_if;
  logic                                valid;
  logic                                ready;
  logic        [ssmg_pkg::FUNC_W-1:0]  func;
  logic signed [ssmg_pkg::VALUE_W-1:0] value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

interface ssmg_out_if;
  logic                          valid;
  logic                          ready;
  logic                          done_ok;
  logic                          table_full;
  logic                          gap_valid;
  logic [ssmg_pkg::GAP_W-1:0]    min_gap;
  logic [ssmg_pkg::POS_W-1:0]    gap_position;
  logic [ssmg_pkg::COUNT_W-1:0]  entry_count;

  modport source (output valid, output done_ok, output table_full, output gap_valid,
                  output min_gap, output gap_position, output entry_count,
                  input ready);
  modport sink   (input valid, input done_ok, input table_full, input gap_valid,
                  input min_gap, input gap_position, input entry_count,
                  output ready);
endinterface

// ===== hw/rtl/ssmg_ram.sv =====
// ----------------------------------------------------------------------------
// ssmg_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module ssmg_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/ssmg_ctrl.sv =====
// ----------------------------------------------------------------------------
// ssmg_ctrl
// Sequencer of the tracker: walks the store entry by entry, a read state then an
// evaluate state for each, for an insert or a remove and then commits the result.
// ----------------------------------------------------------------------------
module ssmg_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic [ssmg_pkg::FUNC_W-1:0]   in_func_i,
  output logic                          in_ready_o,
  input  ssmg_pkg::status_t             status_i,
  output ssmg_pkg::cmd_t                cmd_o
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_INS_RD    = 4'd1;
  localparam logic [3:0] S_INS_EV    = 4'd2;
  localparam logic [3:0] S_INS_PLACE = 4'd3;
  localparam logic [3:0] S_INS_GAPL  = 4'd4;
  localparam logic [3:0] S_INS_GAPR  = 4'd5;
  localparam logic [3:0] S_REM_RD    = 4'd6;
  localparam logic [3:0] S_REM_EV    = 4'd7;
  localparam logic [3:0] S_REM_FIN   = 4'd8;
  localparam logic [3:0] S_RESULT    = 4'd9;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (in_func_i == ssmg_pkg::FUNC_INSERT) begin
            if (status_i.full) begin
              state_d = S_RESULT;
            end else if (status_i.empty) begin
              state_d = S_INS_PLACE;
            end else begin
              state_d = S_INS_RD;
            end
          end else if (status_i.empty) begin
            state_d = S_RESULT;
          end else begin
            state_d = S_REM_RD;
          end
        end
      end
      S_INS_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_INS_EV;
      end
      S_INS_EV: begin
        cmd_o.ins_ev = 1'b1;
        if (!status_i.ge) begin
          state_d = S_INS_GAPL;
        end else if (status_i.idx_zero) begin
          state_d = S_INS_PLACE;
        end else begin
          state_d = S_INS_RD;
        end
      end
      S_INS_PLACE: begin
        cmd_o.ins_place = 1'b1;
        state_d         = S_INS_GAPL;
      end
      S_INS_GAPL: begin
        cmd_o.ins_gapl = 1'b1;
        state_d        = S_INS_GAPR;
      end
      S_INS_GAPR: begin
        cmd_o.ins_gapr = 1'b1;
        state_d        = S_RESULT;
      end
      S_REM_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_REM_EV;
      end
      S_REM_EV: begin
        cmd_o.rem_ev = 1'b1;
        if (status_i.idx_last) begin
          state_d = S_REM_FIN;
        end else begin
          state_d = S_REM_RD;
        end
      end
      S_REM_FIN: begin
        cmd_o.rem_fin = 1'b1;
        state_d       = S_RESULT;
      end
      S_RESULT: begin
        if (!status_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hw/rtl/ssmg_dp.sv =====
// ----------------------------------------------------------------------------
// ssmg_dp
// Datapath of the tracker: the sorted store, the walk index, the neighbor
// registers, the running rescan and the tracked minimum gap.
// ----------------------------------------------------------------------------
module ssmg_dp #(
  parameter int unsigned CAPACITY   = ssmg_pkg::CAPACITY_DEF,
  parameter int unsigned VALUE_BITS = ssmg_pkg::VALUE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ssmg_pkg::cmd_t                cmd_i,
  output ssmg_pkg::status_t             status_o,
  input  logic [ssmg_pkg::FUNC_W-1:0]   in_func_i,
  input  logic [ssmg_pkg::VALUE_W-1:0]  in_value_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic                          out_done_ok_o,
  output logic                          out_table_full_o,
  output logic                          out_gap_valid_o,
  output logic [ssmg_pkg::GAP_W-1:0]    out_min_gap_o,
  output logic [ssmg_pkg::POS_W-1:0]    out_gap_position_o,
  output logic [ssmg_pkg::COUNT_W-1:0]  out_entry_count_o
);

  localparam int unsigned VW = VALUE_BITS;
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned IW = $clog2(CAPACITY + 1);

  // Store interface.
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [VW-1:0] ram_wdata;
  logic          ram_re;
  logic [VW-1:0] ram_rdata;

  // Control registers.
  logic [IW-1:0] count_q, count_d;
  logic          best_valid_q, best_valid_d;
  logic [VW-1:0] best_gap_q, best_gap_d;
  logic [AW-1:0] best_pos_q, best_pos_d;
  logic          found_q, found_d;
  logic          has_left_q, has_left_d;
  logic          has_right_q, has_right_d;
  logic          have_prev_q, have_prev_d;
  logic          scan_valid_q, scan_valid_d;
  logic          ok_q, ok_d;
  logic          full_q, full_d;
  logic          out_valid_q, out_valid_d;

  // Payload registers.
  logic [VW-1:0] v_q, v_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [AW-1:0] p_q, p_d;
  logic [VW-1:0] left_q, left_d;
  logic [VW-1:0] right_q, right_d;
  logic [VW-1:0] prev_q, prev_d;
  logic [VW-1:0] scan_gap_q, scan_gap_d;
  logic [AW-1:0] scan_pos_q, scan_pos_d;
  logic                         o_done_ok_q, o_done_ok_d;
  logic                         o_full_q, o_full_d;
  logic                         o_gap_valid_q, o_gap_valid_d;
  logic [ssmg_pkg::GAP_W-1:0]   o_gap_q, o_gap_d;
  logic [ssmg_pkg::POS_W-1:0]   o_pos_q, o_pos_d;
  logic [ssmg_pkg::COUNT_W-1:0] o_count_q, o_count_d;

  // Shared arithmetic.
  logic [VW-1:0] in_raw;
  logic [VW-1:0] in_offset;
  logic [IW-1:0] idx_inc;
  logic [IW-1:0] idx_dec;
  logic [IW-1:0] n_ins;
  logic [VW-1:0] g_left;
  logic [VW-1:0] g_right;
  logic [VW-1:0] g_scan;
  logic [AW:0]   best_pos_inc;
  logic          hit;

  // Values are held in offset binary so that unsigned order is signed order.
  assign in_raw       = VW'(in_value_i);
  assign in_offset    = {~in_raw[VW-1], in_raw[VW-2:0]};
  assign idx_inc      = idx_q + IW'(1);
  assign idx_dec      = idx_q - IW'(1);
  assign n_ins        = count_q + IW'(1);
  assign g_left       = v_q - left_q;
  assign g_right      = right_q - v_q;
  assign g_scan       = ram_rdata - prev_q;
  assign best_pos_inc = {1'b0, best_pos_q} + (AW+1)'(1);
  assign hit          = !found_q && (ram_rdata == v_q);

  assign status_o.full     = (count_q == IW'(CAPACITY));
  assign status_o.empty    = (count_q == '0);
  assign status_o.ge       = (ram_rdata >= v_q);
  assign status_o.idx_zero = (idx_q == '0);
  assign status_o.idx_last = (idx_inc == count_q);
  assign status_o.out_busy = out_valid_q && !out_ready_i;

  always_comb begin
    ram_we        = 1'b0;
    ram_waddr     = idx_inc[AW-1:0];
    ram_wdata     = v_q;
    ram_re        = cmd_i.rd;

    count_d       = count_q;
    best_valid_d  = best_valid_q;
    best_gap_d    = best_gap_q;
    best_pos_d    = best_pos_q;
    found_d       = found_q;
    has_left_d    = has_left_q;
    has_right_d   = has_right_q;
    have_prev_d   = have_prev_q;
    scan_valid_d  = scan_valid_q;
    ok_d          = ok_q;
    full_d        = full_q;
    out_valid_d   = out_valid_q && !out_ready_i;

    v_d           = v_q;
    idx_d         = idx_q;
    p_d           = p_q;
    left_d        = left_q;
    right_d       = right_q;
    prev_d        = prev_q;
    scan_gap_d    = scan_gap_q;
    scan_pos_d    = scan_pos_q;
    o_done_ok_d   = o_done_ok_q;
    o_full_d      = o_full_q;
    o_gap_valid_d = o_gap_valid_q;
    o_gap_d       = o_gap_q;
    o_pos_d       = o_pos_q;
    o_count_d     = o_count_q;

    if (cmd_i.load) begin
      v_d          = in_offset;
      p_d          = '0;
      found_d      = 1'b0;
      has_left_d   = 1'b0;
      has_right_d  = 1'b0;
      have_prev_d  = 1'b0;
      scan_valid_d = 1'b0;
      ok_d         = 1'b0;
      if (in_func_i == ssmg_pkg::FUNC_REMOVE) begin
        idx_d  = '0;
        full_d = 1'b0;
      end else begin
        // The insert walks down from the top entry.
        idx_d  = count_q - IW'(1);
        full_d = status_o.full;
      end
    end

    if (cmd_i.ins_ev) begin
      ram_we    = 1'b1;
      ram_waddr = idx_inc[AW-1:0];
      if (status_o.ge) begin
        ram_wdata   = ram_rdata;
        right_d     = ram_rdata;
        has_right_d = 1'b1;
        if (status_o.idx_zero) begin
          p_d = '0;
        end else begin
          idx_d = idx_dec;
        end
      end else begin
        ram_wdata  = v_q;
        p_d        = idx_inc[AW-1:0];
        left_d     = ram_rdata;
        has_left_d = 1'b1;
      end
    end

    if (cmd_i.ins_place) begin
      ram_we    = 1'b1;
      ram_waddr = p_q;
      ram_wdata = v_q;
    end

    if (cmd_i.ins_gapl) begin
      count_d = n_ins;
      ok_d    = 1'b1;
      if (n_ins == IW'(2)) begin
        best_valid_d = 1'b1;
        best_gap_d   = has_left_q ? g_left : g_right;
        best_pos_d   = '0;
      end else if (n_ins > IW'(2)) begin
        // The tracked pair moves up when the new entry lands at or below it.
        if (has_left_q && (g_left < best_gap_q)) begin
          best_gap_d = g_left;
          best_pos_d = p_q - AW'(1);
        end else if (p_q <= best_pos_q) begin
          best_pos_d = best_pos_inc[AW-1:0];
        end
      end
    end

    if (cmd_i.ins_gapr) begin
      if ((count_q > IW'(2)) && has_right_q && (g_right < best_gap_q)) begin
        best_gap_d = g_right;
        best_pos_d = p_q;
      end
    end

    if (cmd_i.rem_ev) begin
      idx_d = idx_inc;
      if (hit) begin
        found_d = 1'b1;
        p_d     = idx_q[AW-1:0];
      end else begin
        if (found_q) begin
          ram_we    = 1'b1;
          ram_waddr = idx_dec[AW-1:0];
          ram_wdata = ram_rdata;
        end
        // Leftmost minimum over the entries that survive the removal.
        if (have_prev_q && (!scan_valid_q || (g_scan < scan_gap_q))) begin
          scan_valid_d = 1'b1;
          scan_gap_d   = g_scan;
          scan_pos_d   = found_q ? AW'(idx_q - IW'(2)) : idx_dec[AW-1:0];
        end
        prev_d      = ram_rdata;
        have_prev_d = 1'b1;
      end
    end

    if (cmd_i.rem_fin && found_q) begin
      count_d = count_q - IW'(1);
      ok_d    = 1'b1;
      if (count_q < IW'(3)) begin
        best_valid_d = 1'b0;
        best_gap_d   = '0;
        best_pos_d   = '0;
      end else if ((p_q == best_pos_q) || ({1'b0, p_q} == best_pos_inc)) begin
        best_valid_d = scan_valid_q;
        best_gap_d   = scan_gap_q;
        best_pos_d   = scan_pos_q;
      end else if (p_q < best_pos_q) begin
        best_pos_d = best_pos_q - AW'(1);
      end
    end

    if (cmd_i.emit) begin
      out_valid_d   = 1'b1;
      o_done_ok_d   = ok_q;
      o_full_d      = full_q;
      o_gap_valid_d = best_valid_q;
      o_gap_d       = best_valid_q ? ssmg_pkg::GAP_W'(best_gap_q) : '0;
      o_pos_d       = best_valid_q ? ssmg_pkg::POS_W'(best_pos_q) : '0;
      o_count_d     = ssmg_pkg::COUNT_W'(count_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      best_valid_q <= 1'b0;
      best_gap_q   <= '0;
      best_pos_q   <= '0;
      found_q      <= 1'b0;
      has_left_q   <= 1'b0;
      has_right_q  <= 1'b0;
      have_prev_q  <= 1'b0;
      scan_valid_q <= 1'b0;
      ok_q         <= 1'b0;
      full_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      count_q      <= count_d;
      best_valid_q <= best_valid_d;
      best_gap_q   <= best_gap_d;
      best_pos_q   <= best_pos_d;
      found_q      <= found_d;
      has_left_q   <= has_left_d;
      has_right_q  <= has_right_d;
      have_prev_q  <= have_prev_d;
      scan_valid_q <= scan_valid_d;
      ok_q         <= ok_d;
      full_q       <= full_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q           <= v_d;
    idx_q         <= idx_d;
    p_q           <= p_d;
    left_q        <= left_d;
    right_q       <= right_d;
    prev_q        <= prev_d;
    scan_gap_q    <= scan_gap_d;
    scan_pos_q    <= scan_pos_d;
    o_done_ok_q   <= o_done_ok_d;
    o_full_q      <= o_full_d;
    o_gap_valid_q <= o_gap_valid_d;
    o_gap_q       <= o_gap_d;
    o_pos_q       <= o_pos_d;
    o_count_q     <= o_count_d;
  end

  ssmg_ram #(
    .WIDTH (VW),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o        = out_valid_q;
  assign out_done_ok_o      = o_done_ok_q;
  assign out_table_full_o   = o_full_q;
  assign out_gap_valid_o    = o_gap_valid_q;
  assign out_min_gap_o      = o_gap_q;
  assign out_gap_position_o = o_pos_q;
  assign out_entry_count_o  = o_count_q;

endmodule

// ===== hw/rtl/sorted_set_min_gap_tracker.sv =====
// ----------------------------------------------------------------------------
// sorted_set_min_gap_tracker
// Sorted multiset of signed values with the smallest neighbor gap tracked.
// ----------------------------------------------------------------------------
// Work per operation: an insert reads and compares each held entry not smaller
//   than the value, then checks both new gaps; a remove walks every held entry
//   and then commits; a refused insert or a remove on an empty table goes
//   straight to the result. A result still waiting holds back the next one.
// Throughput: one operation at a time, set by the read-compare-write walk over
//   the store with one write and one read port. Reset: count and
//   minimum gap clear at once; the store is not cleared.
module sorted_set_min_gap_tracker #(
  parameter int unsigned CAPACITY   = ssmg_pkg::CAPACITY_DEF,
  parameter int unsigned VALUE_BITS = ssmg_pkg::VALUE_BITS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  ssmg_in_if.sink         in_i,
  ssmg_out_if.source      out_o
);

  // The controller walks the store; the datapath holds every value and
  // counter. They talk only through the command and status bundles.
  //
  // Insert: the walk starts at the top entry and moves down. Each entry not
  // smaller than the operand is copied one slot up, so the search and the
  // shift share one pass. The first smaller entry, or slot zero, fixes the
  // insert point, and the two neighbors seen on the way give the two new
  // gaps, which are then checked in the GAPL and GAPR states (left first, strict
  // improvement only).
  //
  // Remove: the walk goes up from slot zero. The first equal entry is
  // dropped and every later entry moves one slot down. The same pass keeps a
  // running leftmost minimum over the surviving entries, so when the removed
  // entry was part of the tracked pair the recomputed minimum is ready with
  // no second pass.
  //
  // Results land in an output register, so the next operation can start
  // while a result beat still waits to be taken.

  ssmg_pkg::cmd_t    cmd;
  ssmg_pkg::status_t status;

  ssmg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_func_i  (in_i.func),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ssmg_dp #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .in_func_i          (in_i.func),
    .in_value_i         (in_i.value),
    .out_ready_i        (out_o.ready),
    .out_valid_o        (out_o.valid),
    .out_done_ok_o      (out_o.done_ok),
    .out_table_full_o   (out_o.table_full),
    .out_gap_valid_o    (out_o.gap_valid),
    .out_min_gap_o      (out_o.min_gap),
    .out_gap_position_o (out_o.gap_position),
    .out_entry_count_o  (out_o.entry_count)
  );

  // Once a beat is taken, ready is low in the cycle after.
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("input accepted twice in a row");

  // A refused insert never reports success.
  a_full_not_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.table_full |-> !out_o.done_ok)
    else $error("refused insert reported as done");

  // Without a gap the gap fields read zero.
  a_gap_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.gap_valid |-> (out_o.min_gap == '0) && (out_o.gap_position == '0))
    else $error("gap fields set without a valid gap");

  // A new result is only loaded when the previous one is gone or leaving.
  a_emit_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> !(out_o.valid && !out_o.ready))
    else $error("result register overwritten");

endmodule

// ===== dv/ssmg_min_gap_checker.sv =====
// ----------------------------------------------------------------------------
// ssmg_min_gap_checker
// Watches the operation and result channels of the sorted set minimum gap
// tracker, predicts every result beat from its own copy of the sorted table
// and compares each beat field by field in arrival order.
// ----------------------------------------------------------------------------
module ssmg_min_gap_checker
  import ssmg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  ssmg_in_if          op_mon,
  ssmg_out_if         rep_mon,
  output int unsigned mismatch_count_o,
  output int unsigned pending_count_o,
  output int unsigned checked_count_o,
  output int unsigned refused_count_o,
  output int unsigned missed_count_o,
  output int unsigned peak_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned         TABLE_DEPTH = CAPACITY_DEF;
  // Flipping the sign bit turns signed order into unsigned order, so gaps
  // become plain unsigned differences. VALUE_BITS equals the field width.
  localparam logic [VALUE_W-1:0]  SIGN_FLIP   = {1'b1, {(VALUE_W-1){1'b0}}};

  typedef struct packed {
    logic               done_ok;
    logic               table_full;
    logic               gap_valid;
    logic [GAP_W-1:0]   min_gap;
    logic [POS_W-1:0]   gap_position;
    logic [COUNT_W-1:0] entry_count;
  } gap_report_t;

  logic [VALUE_W-1:0] sorted_keys [TABLE_DEPTH];
  int unsigned        held_n;
  logic [GAP_W-1:0]   low_gap;
  int unsigned        low_pos;
  logic               low_valid;
  gap_report_t        expected_reports [$];

  // Leftmost smallest neighbor gap over the whole table.
  function automatic void rebuild_min_gap();
    int unsigned      i;
    logic [GAP_W-1:0] g;
    if (held_n < 2) begin
      low_valid = 1'b0;
      low_gap   = '0;
      low_pos   = 0;
      return;
    end
    low_valid = 1'b1;
    low_gap   = sorted_keys[1] - sorted_keys[0];
    low_pos   = 0;
    for (i = 2; i < held_n; i++) begin
      g = sorted_keys[i] - sorted_keys[i-1];
      if (g < low_gap) begin
        low_gap = g;
        low_pos = i - 1;
      end
    end
  endfunction

  function automatic bit store_key(logic [VALUE_W-1:0] k);
    int unsigned      p;
    int unsigned      i;
    logic [GAP_W-1:0] g;
    if (held_n >= TABLE_DEPTH) return 1'b0;
    p = 0;
    while (p < held_n && sorted_keys[p] < k) p++;
    for (i = held_n; i > p; i--) sorted_keys[i] = sorted_keys[i-1];
    sorted_keys[p] = k;
    held_n++;
    if (held_n < 2) return 1'b1;
    if (held_n == 2) begin
      low_valid = 1'b1;
      low_gap   = sorted_keys[1] - sorted_keys[0];
      low_pos   = 0;
      return 1'b1;
    end
    if (p <= low_pos) low_pos++;
    // Only a strictly smaller gap moves the tracked pair; left gap first.
    if (p > 0) begin
      g = sorted_keys[p] - sorted_keys[p-1];
      if (g < low_gap) begin
        low_gap = g;
        low_pos = p - 1;
      end
    end
    if (p + 1 < held_n) begin
      g = sorted_keys[p+1] - sorted_keys[p];
      if (g < low_gap) begin
        low_gap = g;
        low_pos = p;
      end
    end
    return 1'b1;
  endfunction

  function automatic bit drop_key(logic [VALUE_W-1:0] k);
    int unsigned p;
    int unsigned i;
    p = 0;
    while (p < held_n && sorted_keys[p] != k) p++;
    if (p >= held_n) return 1'b0;
    for (i = p; i + 1 < held_n; i++) sorted_keys[i] = sorted_keys[i+1];
    held_n--;
    if (held_n < 2 || p == low_pos || p == low_pos + 1) rebuild_min_gap();
    else if (p < low_pos) low_pos--;
    return 1'b1;
  endfunction

  function automatic gap_report_t predict_report(logic [FUNC_W-1:0]  func,
                                                 logic [VALUE_W-1:0] value);
    gap_report_t r;
    r = '0;
    if (func == FUNC_INSERT) begin
      r.done_ok    = store_key(value ^ SIGN_FLIP);
      r.table_full = !r.done_ok;
      if (r.table_full) refused_count_o++;
    end else begin
      r.done_ok = drop_key(value ^ SIGN_FLIP);
      if (!r.done_ok) missed_count_o++;
    end
    r.gap_valid    = low_valid;
    r.min_gap      = low_valid ? low_gap : '0;
    r.gap_position = low_valid ? low_pos[POS_W-1:0] : '0;
    r.entry_count  = held_n[COUNT_W-1:0];
    if (held_n > peak_count_o) peak_count_o = held_n;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch on result beat %0d, expected 0x%0h, got 0x%0h",
               $time, name, checked_count_o, want, got);
      mismatch_count_o++;
    end
  endfunction

  task automatic compare_beat();
    gap_report_t want;
    if (expected_reports.size() == 0) begin
      $display("%0t: result beat with nothing pending, expected none, got count %0d",
               $time, rep_mon.entry_count);
      mismatch_count_o++;
      return;
    end
    want = expected_reports.pop_front();
    checked_count_o++;
    check_field("done_ok", 32'(want.done_ok), 32'(rep_mon.done_ok));
    check_field("table_full", 32'(want.table_full), 32'(rep_mon.table_full));
    check_field("gap_valid", 32'(want.gap_valid), 32'(rep_mon.gap_valid));
    check_field("min_gap", 32'(want.min_gap), 32'(rep_mon.min_gap));
    check_field("gap_position", 32'(want.gap_position), 32'(rep_mon.gap_position));
    check_field("entry_count", 32'(want.entry_count), 32'(rep_mon.entry_count));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_n    = 0;
      low_gap   = '0;
      low_pos   = 0;
      low_valid = 1'b0;
      expected_reports.delete();
      pending_count_o = 0;
    end else begin
      if (rep_mon.valid && rep_mon.ready) compare_beat();
      if (op_mon.valid && op_mon.ready) begin
        expected_reports = {expected_reports, predict_report(op_mon.func, op_mon.value)};
      end
      pending_count_o = expected_reports.size();
    end
  end

endmodule

// ===== dv/tb_sorted_set_min_gap_tracker.sv =====
// ----------------------------------------------------------------------------
// tb_sorted_set_min_gap_tracker
// Drives insert and remove beats into the sorted set minimum gap tracker with
// random pauses on both channels and one long hold-off on the result side,
// and leaves prediction and comparison to the checker placed beside the block.
// ----------------------------------------------------------------------------
module tb_sorted_set_min_gap_tracker;
  timeunit 1ns;
  timeprecision 1ps;

  import ssmg_pkg::*;

  localparam int unsigned CLK_PERIOD      = 20;
  localparam int unsigned RESET_CYCLES    = 6;
  localparam int unsigned RANDOM_OPS      = 700;
  // The slowest operation reads and compares each of up to 64 entries.
  localparam int unsigned DRAIN_CYCLES    = 2 * CAPACITY_DEF + 10;
  // The limit leaves several times the worst case per operation, with the longest
  // pauses on both sides, for some 800 operations.
  localparam longint unsigned CYCLE_LIMIT = 800_000;
  localparam int unsigned HOLD_OFF_AFTER  = 250;
  localparam int unsigned HOLD_OFF_CYCLES = 1500;

  localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

  logic clk_i;
  logic rst_ni;

  ssmg_in_if  op_ch ();
  ssmg_out_if rep_ch ();

  longint unsigned cycles = 0;
  int unsigned     ops_accepted = 0;
  bit              hold_done = 1'b0;

  // Stimulus bookkeeping: which values the table should hold, so that most
  // removes hit a stored value. This never predicts a result.
  logic signed [VALUE_W-1:0] live_values [$];
  logic signed [VALUE_W-1:0] cluster_base;
  int unsigned               cluster_span;
  bit                        sender_steady = 1'b0;
  int unsigned               sender_steady_left = 0;

  int unsigned mismatch_count;
  int unsigned pending_count;
  int unsigned checked_count;
  int unsigned refused_count;
  int unsigned missed_count;
  int unsigned peak_count;

  sorted_set_min_gap_tracker u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (op_ch.sink),
    .out_o  (rep_ch.source)
  );

  ssmg_min_gap_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .op_mon           (op_ch),
    .rep_mon          (rep_ch),
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count),
    .checked_count_o  (checked_count),
    .refused_count_o  (refused_count),
    .missed_count_o   (missed_count),
    .peak_count_o     (peak_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycles <= cycles + 1;

  // Watchdog: a hung handshake ends the run here.
  initial begin : watchdog
    wait (cycles >= CYCLE_LIMIT);
    $display("Timeout after %0d cycles with %0d results outstanding.", cycles, pending_count);
    $display("RESULT: ERROR");
    $finish;
  end

  // Pause length for either channel. Most pauses are zero or short, a few are
  // long; during a steady stretch there are none at all.
  function automatic int unsigned pick_pause(bit steady);
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Values mostly come from a narrow cluster so that duplicates, zero gaps and
  // tied gaps are common; the rest are full-range randoms and the extremes.
  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 5))
          0:       return VALUE_MIN;
          1:       return VALUE_MAX;
          2:       return '0;
          3:       return '1;
          4:       return VALUE_MIN + 1;
          default: return VALUE_MAX - 1;
        endcase
      end
      1, 2:    return $urandom();
      default: return cluster_base + $urandom_range(0, cluster_span);
    endcase
  endfunction

  function automatic void new_cluster();
    cluster_base = $urandom();
    case ($urandom_range(0, 3))
      0:       cluster_span = 2;
      1:       cluster_span = 60;
      2:       cluster_span = 4000;
      default: cluster_span = 32'h0000_FFFF;
    endcase
  endfunction

  // One operation beat. Called right at a rising edge; returns at the edge
  // where the beat was taken, so the next call may drive valid again in the
  // same step without a second assignment to it.
  task automatic send_op(input logic [FUNC_W-1:0] func, input logic signed [VALUE_W-1:0] value);
    int unsigned pause;
    if (sender_steady_left == 0) begin
      sender_steady      = ($urandom_range(0, 3) == 0);
      sender_steady_left = $urandom_range(20, 80);
    end else begin
      sender_steady_left--;
    end
    pause = pick_pause(sender_steady);
    if (pause != 0) begin
      op_ch.valid <= 1'b0;
      repeat (pause) @(posedge clk_i);
    end
    op_ch.valid <= 1'b1;
    op_ch.func  <= func;
    op_ch.value <= value;
    @(posedge clk_i);
    while (!op_ch.ready) @(posedge clk_i);
    ops_accepted++;
  endtask

  task automatic issue_insert(input logic signed [VALUE_W-1:0] value);
    send_op(FUNC_INSERT, value);
    if (live_values.size() < CAPACITY_DEF) live_values = {live_values, value};
  endtask

  task automatic issue_remove(input logic signed [VALUE_W-1:0] value);
    int i;
    send_op(FUNC_REMOVE, value);
    for (i = 0; i < live_values.size(); i++) begin
      if (live_values[i] == value) begin
        live_values.delete(i);
        break;
      end
    end
  endtask

  // Result side: random back-pressure, steady stretches, and once, after a
  // few hundred operations, a long hold-off so that the block fills its
  // result register and stops taking operations.
  initial begin : result_sink
    int unsigned stall_left;
    int unsigned steady_left;
    int unsigned pause;
    bit          steady;
    stall_left   = 0;
    steady_left  = 0;
    steady       = 1'b0;
    rep_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (!hold_done && ops_accepted >= HOLD_OFF_AFTER) begin
        hold_done = 1'b1;
        rep_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end else begin
        if (steady_left == 0) begin
          steady      = ($urandom_range(0, 3) == 0);
          steady_left = $urandom_range(50, 300);
        end else begin
          steady_left--;
        end
        if (stall_left > 0) begin
          stall_left--;
          rep_ch.ready <= 1'b0;
        end else begin
          pause = pick_pause(steady);
          if (pause == 0) begin
            rep_ch.ready <= 1'b1;
          end else begin
            stall_left = pause - 1;
            rep_ch.ready <= 1'b0;
          end
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned op_goal;
    int unsigned steps;
    int unsigned r;
    bit          first_fill;

    rst_ni      = 1'b0;
    op_ch.valid = 1'b0;
    op_ch.func  = FUNC_INSERT;
    op_ch.value = '0;
    new_cluster();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed opening. A remove on the empty table misses. Two equal values
    // make the first gap, which is zero, at position zero. Removing down to
    // one entry clears the gap. The two extremes give the widest gap there is.
    issue_remove(32'sd5);
    issue_insert(32'sd0);
    issue_insert(32'sd0);
    issue_remove(32'sd0);
    issue_remove(32'sd0);
    issue_insert(VALUE_MIN);
    issue_insert(VALUE_MAX);
    // Both new gaps are checked, the left one first.
    issue_insert(-32'sd1);
    issue_insert(32'sd100);
    // 50 lands inside the minimum pair, so one of its gaps must win.
    issue_insert(32'sd50);
    // 150 makes a gap equal to the minimum, which must not move the pair.
    issue_insert(32'sd150);
    // These removes break the minimum pair and force a full rescan.
    issue_remove(32'sd100);
    issue_remove(32'sd50);
    // Absent value: nothing changes.
    issue_remove(32'sd12345);
    // Removing left of the pair shifts the tracked position down.
    issue_remove(VALUE_MIN);
    issue_insert(32'sh5555_5555);
    issue_insert(32'shAAAA_AAAA);
    issue_remove(VALUE_MAX);
    issue_remove(-32'sd1);

    // Random part, in grow and shrink episodes. The first grow, and about a
    // quarter of the later ones, push past a full table so that refused
    // inserts keep turning up.
    op_goal    = ops_accepted + RANDOM_OPS;
    first_fill = 1'b1;
    while (ops_accepted < op_goal) begin
      new_cluster();
      if (first_fill || $urandom_range(0, 3) == 0) begin
        first_fill = 1'b0;
        steps = CAPACITY_DEF - live_values.size() + $urandom_range(1, 4);
        repeat (steps) issue_insert(pick_value());
      end else begin
        steps = $urandom_range(2, 30);
        repeat (steps) begin
          if ($urandom_range(0, 99) < 85) issue_insert(pick_value());
          else issue_remove(pick_value());
        end
      end

      // Shrink either all the way down or part of the way.
      if ($urandom_range(0, 1) == 0) steps = live_values.size() + 2;
      else steps = $urandom_range(1, live_values.size() + 1);
      repeat (steps) begin
        r = $urandom_range(0, 99);
        if (r < 80 && live_values.size() > 0) begin
          issue_remove(live_values[$urandom_range(0, live_values.size() - 1)]);
        end else if (r < 92) begin
          issue_remove(pick_value());
        end else begin
          issue_insert(pick_value());
        end
      end
    end
    op_ch.valid <= 1'b0;

    // The last expectation is queued at the edge where its beat was taken.
    @(posedge clk_i);
    wait (pending_count == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Checked %0d result beats from %0d operations: %0d inserts refused on a full table,",
             checked_count, ops_accepted, refused_count);
    $display("%0d removes of absent values, peak fill %0d of %0d, one %0d-cycle result hold-off.",
             missed_count, peak_count, CAPACITY_DEF, HOLD_OFF_CYCLES);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
